FILE: rtl/bfiq_pkg.sv
package bfiq_pkg;

    localparam int HASH_W        = 64;
    localparam int FILTER_BITS_W = 21;
    localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RESET = 21'd1048576;

    // Item modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // APB register map: one word register, selected by paddr[2]
    localparam int   APB_ADDR_W      = 3;
    localparam int   APB_DATA_W      = 32;
    localparam logic REG_FILTER_BITS = 1'b0;

    // Control part of an item travelling from front to back
    typedef struct packed {
        logic mode;
        logic last;
    } bfiq_op_t;

endpackage

FILE: rtl/bfiq_ram.sv
module bfiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bfiq_front.sv
module bfiq_front
    import bfiq_pkg::*;
#(
    parameter int MAX_FILTER_BITS = 1048576,
    localparam int POS_W = $clog2(MAX_FILTER_BITS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     mode,
    input  logic [HASH_W-1:0]        hash_value,
    input  logic                     last_hash,
    input  logic [FILTER_BITS_W-1:0] filter_bits,
    output logic                     busy,
    output logic                     push_valid,
    input  logic                     push_ready,
    output bfiq_op_t                 push_op,
    output logic [POS_W-1:0]         push_pos
);

    localparam int SIZE_W = $clog2(MAX_FILTER_BITS + 1);
    localparam int CMP_W  = (SIZE_W > FILTER_BITS_W) ? SIZE_W : FILTER_BITS_W;
    localparam int CNT_W  = $clog2(HASH_W);

    localparam logic [CMP_W-1:0] LIMIT_SIZE = CMP_W'(MAX_FILTER_BITS & ~7);
    localparam logic [CMP_W-1:0] MIN_SIZE   = CMP_W'(8);
    localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(HASH_W - 1);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    bfiq_op_t          op_reg, op_next;

    logic [CMP_W-1:0]  fb_ext;
    logic [CMP_W-1:0]  size_sel;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic              fits;

    // Round the size down to whole bytes, then clamp into the store
    always_comb
    begin
        fb_ext = CMP_W'({filter_bits[FILTER_BITS_W-1:3], 3'b000});
        if (fb_ext == '0)
        begin
            size_sel = MIN_SIZE;
        end
        else if (fb_ext > LIMIT_SIZE)
        begin
            size_sel = LIMIT_SIZE;
        end
        else
        begin
            size_sel = fb_ext;
        end
    end

    // One restoring remainder step per cycle, most significant hash bit first
    assign trial = {rem_reg, hash_reg[HASH_W-1]};
    assign diff  = trial - {1'b0, size_reg};
    assign fits  = (trial >= {1'b0, size_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hash_next  = hash_reg;
        rem_next   = rem_reg;
        size_next  = size_reg;
        op_next    = op_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    hash_next    = hash_value;
                    rem_next     = '0;
                    cnt_next     = '0;
                    size_next    = size_sel[SIZE_W-1:0];
                    op_next.mode = mode;
                    op_next.last = last_hash;
                    state_next   = F_DIV;
                end
            end
            F_DIV:
            begin
                rem_next  = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
                hash_next = {hash_reg[HASH_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        hash_reg <= hash_next;
        rem_reg  <= rem_next;
        size_reg <= size_next;
        op_reg   <= op_next;
    end

    assign busy       = (state_reg != F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_op    = op_reg;
    assign push_pos   = rem_reg[POS_W-1:0];

endmodule

FILE: rtl/bfiq_queue.sv
module bfiq_queue
    import bfiq_pkg::*;
#(
    parameter int POS_W = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  bfiq_op_t         push_op,
    input  logic [POS_W-1:0] push_pos,
    output logic             pop_valid,
    input  logic             pop_ready,
    output bfiq_op_t         pop_op,
    output logic [POS_W-1:0] pop_pos
);

    localparam int DEPTH = 2;

    bfiq_op_t         op_mem_reg  [DEPTH];
    logic [POS_W-1:0] pos_mem_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_op     = op_mem_reg[rd_ptr_reg];
    assign pop_pos    = pos_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            op_mem_reg[wr_ptr_reg]  <= push_op;
            pos_mem_reg[wr_ptr_reg] <= push_pos;
        end
    end

endmodule

FILE: rtl/bfiq_back.sv
module bfiq_back
    import bfiq_pkg::*;
#(
    parameter int MAX_FILTER_BITS = 1048576,
    localparam int POS_W = $clog2(MAX_FILTER_BITS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  bfiq_op_t         pop_op,
    input  logic [POS_W-1:0] pop_pos,
    output logic             clearing,
    output logic             done,
    output logic             member
);

    localparam int STORE_BYTES = (MAX_FILTER_BITS + 7) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_CHECK = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              all_set_reg, all_set_next;
    logic              done_reg, done_next;
    logic              member_reg, member_next;
    bfiq_op_t          op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [2:0]        off_reg, off_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic [7:0]        bit_mask;
    logic              bit_hit;
    logic              flag_now;

    bfiq_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (pop_pos[ADDR_W+2:3]),
        .rdata (ram_rdata)
    );

    // Bit n of the filter sits in byte n/8, most significant bit first
    assign bit_mask = 8'h80 >> off_reg;
    assign bit_hit  = |(ram_rdata & bit_mask);
    assign flag_now = all_set_reg & bit_hit;

    assign pop_ready = (state_reg == B_IDLE);
    assign clearing  = (state_reg == B_CLEAR);
    assign done      = done_reg;
    assign member    = member_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        all_set_next = all_set_reg;
        done_next    = 1'b0;
        member_next  = member_reg;
        op_next      = op_reg;
        addr_next    = addr_reg;
        off_next     = off_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = ram_rdata | bit_mask;
        case (state_reg)
            B_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    op_next    = pop_op;
                    addr_next  = pop_pos[ADDR_W+2:3];
                    off_next   = pop_pos[2:0];
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (op_reg.mode == MODE_INSERT)
                begin
                    ram_we = 1'b1;
                end
                else if (op_reg.last)
                begin
                    done_next    = 1'b1;
                    member_next  = flag_now;
                    all_set_next = 1'b1;
                end
                else
                begin
                    all_set_next = flag_now;
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
            all_set_reg <= 1'b1;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            all_set_reg <= all_set_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        member_reg <= member_next;
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        off_reg    <= off_next;
    end

`ifndef SYNTHESIS
    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !done_reg)
        else $error("result strobe during store clearing");

    a_result_from_last_query: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == B_CHECK && op_reg.mode == MODE_QUERY && op_reg.last))
        else $error("result strobe without a last query hash");

    a_store_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == B_CLEAR
                    || (state_reg == B_CHECK && op_reg.mode == MODE_INSERT)))
        else $error("bit store written outside clearing or insert");
`endif

endmodule

FILE: rtl/bloom_filter_insert_query.sv
// Channel   Handshake                    Payload
// -------   ---------------------------  ------------------------------------
// item in   start, busy (accept: !busy)  mode, hash_value[63:0], last_hash
// result    done (one-cycle strobe)      member
// config    APB: psel, penable, pwrite,  paddr[2:0], pwdata, prdata;
//           pready (tied high)           filter_bits at byte address 0
//
// An item is taken at the edge where start is high and busy is low. The front
// reduces the hash modulo the filter size one bit per cycle in a 64-step
// remainder loop; busy stays high until the item's position is pushed into
// the queue, so no new item is taken before the last one has left the front.
// The back end reads each item's byte from the bit store, then tests it or
// writes it back; a query's result passes the queue, the store read and the
// check state before done and member are registered. After reset the back
// end sweeps the store to zero, one byte a cycle (MAX_FILTER_BITS/8 bytes,
// 131072 at the default size), holding busy high; configuration writes are
// taken throughout. The receiver cannot stall; done is a one-cycle strobe.
module bloom_filter_insert_query
    import bfiq_pkg::*;
#(
    parameter int MAX_FILTER_BITS = 1048576
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // items
    input  logic                  start,
    output logic                  busy,
    input  logic                  mode,
    input  logic [HASH_W-1:0]     hash_value,
    input  logic                  last_hash,
    // results
    output logic                  done,
    output logic                  member
);

    localparam int POS_W = $clog2(MAX_FILTER_BITS);

    logic [FILTER_BITS_W-1:0] filter_bits_reg, filter_bits_next;
    logic                     cfg_write;

    logic                     accept;
    logic                     front_busy;
    logic                     clearing;

    logic                     push_valid;
    logic                     push_ready;
    bfiq_op_t                 push_op;
    logic [POS_W-1:0]         push_pos;
    logic                     pop_valid;
    logic                     pop_ready;
    bfiq_op_t                 pop_op;
    logic [POS_W-1:0]         pop_pos;

    // Configuration: a write completes on the access cycle; anything but
    // the filter size register is dropped.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        filter_bits_next = filter_bits_reg;
        if (cfg_write && (paddr[2] == REG_FILTER_BITS))
        begin
            filter_bits_next = pwdata[FILTER_BITS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bits_reg <= FILTER_BITS_RESET;
        end
        else
        begin
            filter_bits_reg <= filter_bits_next;
        end
    end

    assign prdata = (paddr[2] == REG_FILTER_BITS) ? APB_DATA_W'(filter_bits_reg)
                                                  : '0;

    // Hold off new transactions while the front is dividing or waiting to push,
    // or the store is still being cleared.
    assign busy   = front_busy || clearing;
    assign accept = start && !busy;

    bfiq_front #(
        .MAX_FILTER_BITS (MAX_FILTER_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .hash_value  (hash_value),
        .last_hash   (last_hash),
        .filter_bits (filter_bits_reg),
        .busy        (front_busy),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_op     (push_op),
        .push_pos    (push_pos)
    );

    // Short queue so the front can finish the next division while the
    // back end is still on the store.
    bfiq_queue #(
        .POS_W (POS_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .push_pos   (push_pos),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op),
        .pop_pos    (pop_pos)
    );

    bfiq_back #(
        .MAX_FILTER_BITS (MAX_FILTER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .pop_pos   (pop_pos),
        .clearing  (clearing),
        .done      (done),
        .member    (member)
    );

endmodule
